[rtl/wsfr_pkg.sv]
// shared constants, types and a helper function for the websocket frame receiver
package wsfr_pkg;

  localparam int MSG_COUNT_WIDTH_DEF = 32;
  localparam logic [31:0] MAX_MSG_RESET = 32'd1048576;

  // parse phase codes
  localparam logic [2:0] PH_OPCODE  = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CLOSED  = 3'd5;
  localparam logic [2:0] PH_FAILED  = 3'd6;

  // error codes
  localparam logic [3:0] ERR_NONE    = 4'd0;
  localparam logic [3:0] ERR_RSV     = 4'd1;
  localparam logic [3:0] ERR_OPCODE  = 4'd2;
  localparam logic [3:0] ERR_CONT    = 4'd3;
  localparam logic [3:0] ERR_FRAGCTL = 4'd4;
  localparam logic [3:0] ERR_CTLLONG = 4'd5;
  localparam logic [3:0] ERR_NOMASK  = 4'd6;
  localparam logic [3:0] ERR_NONCAN  = 4'd7;
  localparam logic [3:0] ERR_LEN63   = 4'd8;
  localparam logic [3:0] ERR_BIG     = 4'd9;
  localparam logic [3:0] ERR_CLOSE   = 4'd10;
  localparam logic [3:0] ERR_UTF8    = 4'd11;

  // opcodes
  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  localparam logic [1:0] ST_ACTIVE = 2'd0;
  localparam logic [1:0] ST_CLOSED = 2'd1;
  localparam logic [1:0] ST_FAILED = 2'd2;

  // incremental utf-8 decoder state
  typedef struct packed {
    logic [20:0] value;
    logic [1:0]  floor;
    logic [1:0]  left;
    logic        bad;
  } utf8_t;

  localparam utf8_t UTF8_CLEAR = '{value: 21'd0, floor: 2'd0, left: 2'd0, bad: 1'b0};

  // one result item
  typedef struct packed {
    logic        consumed;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        payload_control;
    logic        message_done;
    logic [3:0]  message_opcode;
    logic [12:0] close_code;
    logic [1:0]  status;
    logic [3:0]  error_code;
  } result_t;

  function automatic logic close_code_ok(input logic [15:0] c);
    close_code_ok = (c >= 16'd1000 && c <= 16'd1003) || (c >= 16'd1007 && c <= 16'd1014) ||
                    (c >= 16'd3000 && c <= 16'd4999);
  endfunction

endpackage

[rtl/websocket_frame_receiver.sv]
// top level of the websocket frame receiver
// Server-side WebSocket frame receiver taking one stream byte per request and
// giving one result per request. A byte enters every cycle when the output
// side keeps up: all parsing is one pass of logic between the input register
// and the result register, so the rate is one byte per clock and each result
// is taken from its byte in the input register. Payload bytes are unmasked and
// streamed out before the frame's verdict; text and close-reason UTF-8 errors
// are reported when the frame that ends them finishes. After a valid close or
// any error every later byte is refused (consumed 0) and status repeats.
module websocket_frame_receiver #(
  parameter int MESSAGE_COUNT_WIDTH = wsfr_pkg::MSG_COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_consumed,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_control,
  output logic        out_message_done,
  output logic [3:0]  out_message_opcode,
  output logic [12:0] out_close_code,
  output logic [1:0]  out_status,
  output logic [3:0]  out_error_code
);

  localparam int MCW = MESSAGE_COUNT_WIDTH;
  localparam logic [MCW-1:0] CAP = {MCW{1'b1}};

  // configuration
  logic [31:0] max_msg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) max_msg_r <= wsfr_pkg::MAX_MSG_RESET;
    else if (cfg_we) max_msg_r <= cfg_wdata;
  end

  // effective limit, registered since it must only change when idle; the block does not enforce this
  logic [MCW-1:0] limit_r;
  always_ff @(posedge clk) begin
    if ({{(64-MCW){1'b0}}, CAP} < {32'd0, max_msg_r}) limit_r <= CAP;
    else limit_r <= MCW'({32'd0, max_msg_r});
  end

  // input and output registers
  logic       in_full_r;
  logic [7:0] in_byte_r;
  logic       out_full_r;
  wsfr_pkg::result_t res_r, res_nxt;
  logic       advance;

  assign advance  = in_full_r && (!out_full_r || !out_stall);
  assign in_stall = in_full_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) in_full_r <= 1'b0;
    else if (!in_stall) in_full_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_byte_r <= in_data_byte;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_full_r <= 1'b0;
    else if (advance) out_full_r <= 1'b1;
    else if (!out_stall) out_full_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (advance) res_r <= res_nxt;
  end

  // parser state
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  fop_r, fop_nxt;
  logic        ffin_r, ffin_nxt;
  logic        fctl_r, fctl_nxt;
  logic        frag_r, frag_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [6:0]  ltag_r, ltag_nxt;
  logic [3:0]  lleft_r, lleft_nxt;
  logic [63:0] pleft_r, pleft_nxt;
  logic [7:0]  key_r [4];
  logic [7:0]  key_nxt [4];
  logic [1:0]  midx_r, midx_nxt;
  logic [MCW-1:0] mlen_r, mlen_nxt;
  logic [6:0]  ccnt_r, ccnt_nxt;
  logic [15:0] ccode_r, ccode_nxt;
  wsfr_pkg::utf8_t du_r, du_nxt, cu_r, cu_nxt, du_step, cu_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsfr_pkg::PH_OPCODE;
      fop_r <= '0; ffin_r <= 1'b0; fctl_r <= 1'b0; frag_r <= 1'b0; kind_r <= '0;
      ltag_r <= '0; lleft_r <= '0; pleft_r <= '0; midx_r <= '0; mlen_r <= '0;
      ccnt_r <= '0; ccode_r <= '0;
      du_r <= wsfr_pkg::UTF8_CLEAR; cu_r <= wsfr_pkg::UTF8_CLEAR;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      fop_r <= fop_nxt; ffin_r <= ffin_nxt; fctl_r <= fctl_nxt; frag_r <= frag_nxt;
      kind_r <= kind_nxt; ltag_r <= ltag_nxt; lleft_r <= lleft_nxt; pleft_r <= pleft_nxt;
      midx_r <= midx_nxt; mlen_r <= mlen_nxt; ccnt_r <= ccnt_nxt; ccode_r <= ccode_nxt;
      du_r <= du_nxt; cu_r <= cu_nxt;
      for (int i = 0; i < 4; i++) key_r[i] <= key_nxt[i];
    end
  end

  // unmasked byte and utf-8 steppers
  logic [7:0] ub;
  assign ub = in_byte_r ^ key_r[midx_r];

  wsfr_utf8 u_data_utf8  (.cur(du_r), .b(ub), .nxt(du_step));
  wsfr_utf8 u_close_utf8 (.cur(cu_r), .b(ub), .nxt(cu_step));

  // next-state and result logic
  logic [3:0]  err;
  logic        do_len, do_frame;
  logic [63:0] plen;
  logic [MCW-1:0] room;
  logic [15:0] code;
  logic [7:0]  b;

  always_comb begin
    b = in_byte_r;
    phase_nxt = phase_r; fop_nxt = fop_r; ffin_nxt = ffin_r; fctl_nxt = fctl_r;
    frag_nxt = frag_r; kind_nxt = kind_r; ltag_nxt = ltag_r; lleft_nxt = lleft_r;
    pleft_nxt = pleft_r; midx_nxt = midx_r; mlen_nxt = mlen_r; ccnt_nxt = ccnt_r;
    ccode_nxt = ccode_r; du_nxt = du_r; cu_nxt = cu_r;
    for (int i = 0; i < 4; i++) key_nxt[i] = key_r[i];
    res_nxt = '0;
    err = wsfr_pkg::ERR_NONE;
    do_len = 1'b0; do_frame = 1'b0;
    plen = pleft_r;
    room = (limit_r > mlen_r) ? limit_r - mlen_r : '0;
    code = 16'd0;

    if (phase_r > wsfr_pkg::PH_PAYLOAD) begin
      res_nxt.status = (phase_r == wsfr_pkg::PH_CLOSED) ? wsfr_pkg::ST_CLOSED
                                                        : wsfr_pkg::ST_FAILED;
    end else begin
      res_nxt.consumed = 1'b1;
      unique case (phase_r)
        wsfr_pkg::PH_OPCODE: begin
          if (b[6:4] != 3'd0) begin
            err = wsfr_pkg::ERR_RSV;
          end else begin
            fop_nxt = b[3:0]; ffin_nxt = b[7]; fctl_nxt = b[3];
            phase_nxt = wsfr_pkg::PH_LENGTH;
            case (b[3:0]) inside
              wsfr_pkg::OP_CONT: if (!frag_r) err = wsfr_pkg::ERR_CONT;
              wsfr_pkg::OP_TEXT, wsfr_pkg::OP_BINARY: begin
                if (frag_r) err = wsfr_pkg::ERR_CONT;
                else begin
                  kind_nxt = b[3:0]; mlen_nxt = '0; du_nxt = wsfr_pkg::UTF8_CLEAR;
                end
              end
              wsfr_pkg::OP_CLOSE, wsfr_pkg::OP_PING, wsfr_pkg::OP_PONG: begin
                if (!b[7]) err = wsfr_pkg::ERR_FRAGCTL;
                else begin
                  ccnt_nxt = '0; ccode_nxt = '0; cu_nxt = wsfr_pkg::UTF8_CLEAR;
                end
              end
              default: err = wsfr_pkg::ERR_OPCODE;
            endcase
          end
        end
        wsfr_pkg::PH_LENGTH: begin
          if (!b[7]) err = wsfr_pkg::ERR_NOMASK;
          else begin
            ltag_nxt = b[6:0];
            if (fctl_r && b[6:0] > 7'd125) err = wsfr_pkg::ERR_CTLLONG;
            else if (b[6:0] >= 7'd126) begin
              pleft_nxt = '0;
              lleft_nxt = (b[6:0] == 7'd126) ? 4'd2 : 4'd8;
              phase_nxt = wsfr_pkg::PH_EXTLEN;
            end else begin
              plen = {57'd0, b[6:0]};
              pleft_nxt = plen;
              do_len = 1'b1;
            end
          end
        end
        wsfr_pkg::PH_EXTLEN: begin
          if (lleft_r == 4'd8 && b[7]) err = wsfr_pkg::ERR_LEN63;
          else begin
            plen = {pleft_r[55:0], b};
            pleft_nxt = plen;
            lleft_nxt = lleft_r - 4'd1;
            if (lleft_r == 4'd1) do_len = 1'b1;
          end
        end
        wsfr_pkg::PH_MASK: begin
          key_nxt[midx_r] = b;
          midx_nxt = midx_r + 2'd1;
          if (midx_r == 2'd3) begin
            phase_nxt = wsfr_pkg::PH_PAYLOAD;
            if (pleft_r == 64'd0) do_frame = 1'b1;
          end
        end
        wsfr_pkg::PH_PAYLOAD: begin
          midx_nxt = midx_r + 2'd1;
          res_nxt.payload_valid = 1'b1;
          res_nxt.payload_byte = ub;
          res_nxt.payload_control = fctl_r;
          if (fctl_r) begin
            if (fop_r == wsfr_pkg::OP_CLOSE) begin
              if (ccnt_r < 7'd2) ccode_nxt = {ccode_r[7:0], ub};
              else cu_nxt = cu_step;
            end
            if (ccnt_r < 7'd127) ccnt_nxt = ccnt_r + 7'd1;
          end else if (kind_r == wsfr_pkg::OP_TEXT) begin
            du_nxt = du_step;
          end
          if (pleft_r != 64'd0) pleft_nxt = pleft_r - 64'd1;
          if (pleft_r <= 64'd1) do_frame = 1'b1;
        end
        default: ;
      endcase

      // header completion checks
      if (do_len) begin
        if ((ltag_nxt == 7'd126 && plen < 64'd126) ||
            (ltag_nxt == 7'd127 && plen < 64'd65536)) begin
          err = wsfr_pkg::ERR_NONCAN;
        end else if (!fctl_r && plen > {{(64-MCW){1'b0}}, room}) begin
          err = wsfr_pkg::ERR_BIG;
        end else begin
          if (!fctl_r) mlen_nxt = mlen_r + plen[MCW-1:0];
          if (fop_r == wsfr_pkg::OP_CLOSE && plen == 64'd1) err = wsfr_pkg::ERR_CLOSE;
          else begin
            midx_nxt = '0;
            phase_nxt = wsfr_pkg::PH_MASK;
          end
        end
      end

      // frame completion
      if (do_frame) begin
        phase_nxt = wsfr_pkg::PH_OPCODE;
        if (!fctl_r) begin
          frag_nxt = !ffin_r;
          if (ffin_r) begin
            if (kind_r == wsfr_pkg::OP_TEXT && (du_nxt.bad || du_nxt.left != 2'd0))
              err = wsfr_pkg::ERR_UTF8;
            else begin
              res_nxt.message_done = 1'b1;
              res_nxt.message_opcode = kind_r;
            end
          end
        end else begin
          if (fop_r == wsfr_pkg::OP_CLOSE) begin
            phase_nxt = wsfr_pkg::PH_CLOSED;
            if (ccnt_nxt != 7'd0) begin
              code = ccode_nxt;
              if (!wsfr_pkg::close_code_ok(code)) err = wsfr_pkg::ERR_CLOSE;
              else if (cu_nxt.bad || cu_nxt.left != 2'd0) err = wsfr_pkg::ERR_UTF8;
            end
          end
          res_nxt.message_done = 1'b1;
          res_nxt.message_opcode = fop_r;
          res_nxt.close_code = code[12:0];
        end
      end

      // failure overrides the phase and the message results
      if (err != wsfr_pkg::ERR_NONE) begin
        phase_nxt = wsfr_pkg::PH_FAILED;
        res_nxt.message_done = 1'b0;
        res_nxt.message_opcode = '0;
        res_nxt.close_code = '0;
        res_nxt.error_code = err;
      end
      res_nxt.status = (phase_nxt == wsfr_pkg::PH_CLOSED) ? wsfr_pkg::ST_CLOSED :
                       (phase_nxt == wsfr_pkg::PH_FAILED) ? wsfr_pkg::ST_FAILED :
                       wsfr_pkg::ST_ACTIVE;
    end
  end

  // outputs
  assign out_valid           = out_full_r;
  assign out_consumed        = res_r.consumed;
  assign out_payload_valid   = res_r.payload_valid;
  assign out_payload_byte    = res_r.payload_byte;
  assign out_payload_control = res_r.payload_control;
  assign out_message_done    = res_r.message_done;
  assign out_message_opcode  = res_r.message_opcode;
  assign out_close_code      = res_r.close_code;
  assign out_status          = res_r.status;
  assign out_error_code      = res_r.error_code;

`ifndef NO_ASSERTIONS
  // an error always reports a failed status
  a_err_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != wsfr_pkg::ERR_NONE |-> out_status == wsfr_pkg::ST_FAILED)
    else $error("error without failed status");
  // refused bytes never carry payload
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_consumed |-> !out_payload_valid && !out_message_done)
    else $error("refused byte carries data");
  // terminal phase stays terminal
  a_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r > wsfr_pkg::PH_PAYLOAD |=> phase_r == $past(phase_r))
    else $error("left terminal phase");
`endif

endmodule

[rtl/wsfr_utf8.sv]
// one-byte step of the incremental utf-8 checker
module wsfr_utf8 (
  input  wsfr_pkg::utf8_t cur,
  input  logic [7:0]      b,
  output wsfr_pkg::utf8_t nxt
);

  logic [20:0] val_sh;
  logic [20:0] minimum;

  always_comb begin
    nxt = cur;
    val_sh = {cur.value[14:0], b[5:0]};
    case (cur.floor)
      2'd0:    minimum = 21'h80;
      2'd1:    minimum = 21'h800;
      default: minimum = 21'h10000;
    endcase
    if (!cur.bad) begin
      if (cur.left != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          nxt.bad = 1'b1;
        end else begin
          nxt.value = val_sh;
          nxt.left = cur.left - 2'd1;
          if (cur.left == 2'd1 && (val_sh < minimum || val_sh > 21'h10ffff ||
              (val_sh >= 21'hd800 && val_sh <= 21'hdfff))) begin
            nxt.bad = 1'b1;
          end
        end
      end else if (b <= 8'h7f) begin
        nxt = cur;
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
        nxt.value = {16'd0, b[4:0]};
        nxt.floor = 2'd0;
        nxt.left = 2'd1;
      end else if (b >= 8'he0 && b <= 8'hef) begin
        nxt.value = {17'd0, b[3:0]};
        nxt.floor = 2'd1;
        nxt.left = 2'd2;
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
        nxt.value = {18'd0, b[2:0]};
        nxt.floor = 2'd2;
        nxt.left = 2'd3;
      end else begin
        nxt.bad = 1'b1;
      end
    end
  end

endmodule
